// ----- design/shutseq_pkg.sv -----
// Package for the shutter sequencer: event codes, reply status codes,
// register addresses and the result record type. No dependencies.
package shutseq_pkg;

    typedef enum logic [2:0] {
        FUNC_REPORT = 3'd0,
        FUNC_QUIT   = 3'd1,
        FUNC_DATA   = 3'd2,
        FUNC_MANUAL = 3'd3,
        FUNC_TICK   = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_GOOD  = 2'd0,
        ST_RETRY = 2'd1,
        ST_CRIT  = 2'd2
    } status_t;

    localparam logic       REG_POWERUP      = 1'b0;
    localparam logic       REG_FAIL         = 1'b1;
    localparam logic [7:0] POWERUP_RESET    = 8'd15;
    localparam logic [7:0] FAIL_RESET       = 8'd3;

    typedef struct packed {
        logic       watchdog_fired;
        logic       lockout_busy;
        logic       reply_deferred;
        status_t    reply_status;
        logic       reply_valid;
        logic       cmd_open;
        logic       cmd_valid;
    } result_t;

endpackage

// ----- design/shutter_sequencer_with_lockout.sv -----
// Top level of the shutter sequencer with power-up lockout and fail watchdog.
// Depends on shutseq_pkg for event codes, status codes and the result type.
//
//  Channel   Direction  Contents
//  s_axis    in         one event: tuser = kind, tdata = flags
//  m_axis    out        one result per event: command, reply, lockout, watchdog
//  APB       in/out     powerup_seconds at 0x0, fail_seconds at 0x4
//
// Each event is handled in one combinational pass that computes the state
// update and the result; the result is held in an output register.
// A new event is accepted every cycle while the output register is empty or
// being drained, so the input stalls in each cycle the result side holds off.
// Reset clears all state and loads the register defaults; no clearing pass.
module shutter_sequencer_with_lockout
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,  // open_flag, auto_mode, is_critical, 5'b0
    input  shutseq_pkg::func_t        s_tuser,  // func
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [7:0]                m_tdata,  // cmd_valid, cmd_open, reply_valid,
                                                // reply_status[1:0], reply_deferred,
                                                // lockout_busy, watchdog_fired
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import shutseq_pkg::*;

    logic [7:0] powerup_reg;
    logic [7:0] fail_reg;

    logic       reported_reg,     reported_next;
    logic       goal_reg,         goal_next;
    logic       lock_active_reg,  lock_active_next;
    logic [7:0] lock_count_reg,   lock_count_next;
    logic       wd_active_reg,    wd_active_next;
    logic [7:0] wd_count_reg,     wd_count_next;
    logic       pending_reg,      pending_next;

    logic       out_valid_reg;
    result_t    out_reg,          out_next;

    logic       accept;
    logic       open_flag;
    logic       auto_mode;
    logic       is_critical;

    assign open_flag   = s_tdata[0];
    assign auto_mode   = s_tdata[1];
    assign is_critical = s_tdata[2];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // Configuration port
    assign pready = 1'b1;

    always_comb
    begin
        if (paddr[2] == REG_FAIL)
        begin
            prdata = {24'd0, fail_reg};
        end
        else
        begin
            prdata = {24'd0, powerup_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            powerup_reg <= POWERUP_RESET;
            fail_reg    <= FAIL_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2] == REG_FAIL)
            begin
                fail_reg <= pwdata[7:0];
            end
            else
            begin
                powerup_reg <= pwdata[7:0];
            end
        end
    end

    // Event processing. A drive command sets the goal, rearms the watchdog
    // and, when it opens, stops the lockout.
    always_comb
    begin
        reported_next    = reported_reg;
        goal_next        = goal_reg;
        lock_active_next = lock_active_reg;
        lock_count_next  = lock_count_reg;
        wd_active_next   = wd_active_reg;
        wd_count_next    = wd_count_reg;
        pending_next     = pending_reg;
        out_next         = '0;

        case (s_tuser)
            FUNC_REPORT:
            begin
                reported_next  = open_flag;
                wd_active_next = 1'b0;
                if (lock_active_reg)
                begin
                    lock_active_next = 1'b0;
                    lock_count_next  = 8'd0;
                end
                if (pending_reg)
                begin
                    out_next.reply_valid    = 1'b1;
                    out_next.reply_deferred = 1'b1;
                    out_next.reply_status   = (open_flag == goal_reg) ? ST_GOOD : ST_RETRY;
                    pending_next            = 1'b0;
                end
                if (open_flag)
                begin
                    if (!goal_reg)
                    begin
                        // Shutter opened on its own: send it closed again.
                        goal_next          = 1'b0;
                        out_next.cmd_valid = 1'b1;
                        wd_active_next     = 1'b1;
                        wd_count_next      = fail_reg;
                    end
                end
                else
                begin
                    lock_active_next = 1'b1;
                    lock_count_next  = powerup_reg;
                end
            end
            FUNC_QUIT, FUNC_DATA:
            begin
                if ((s_tuser == FUNC_QUIT) ? (auto_mode && reported_reg)
                                           : (is_critical && reported_reg))
                begin
                    goal_next          = 1'b0;
                    out_next.cmd_valid = 1'b1;
                    wd_active_next     = 1'b1;
                    wd_count_next      = fail_reg;
                    pending_next       = 1'b1;
                end
                else if (s_tuser == FUNC_QUIT || is_critical || !auto_mode || reported_reg)
                begin
                    out_next.reply_valid = 1'b1;
                    out_next.reply_status = ST_GOOD;
                end
                else if (lock_active_reg)
                begin
                    out_next.reply_valid  = 1'b1;
                    out_next.reply_status = ST_RETRY;
                end
                else
                begin
                    goal_next          = 1'b1;
                    out_next.cmd_valid = 1'b1;
                    out_next.cmd_open  = 1'b1;
                    wd_active_next     = 1'b1;
                    wd_count_next      = fail_reg;
                    lock_active_next   = 1'b0;
                    pending_next       = 1'b1;
                end
            end
            FUNC_MANUAL:
            begin
                goal_next          = open_flag;
                out_next.cmd_valid = 1'b1;
                out_next.cmd_open  = open_flag;
                wd_active_next     = 1'b1;
                wd_count_next      = fail_reg;
                if (open_flag)
                begin
                    lock_active_next = 1'b0;
                end
            end
            FUNC_TICK:
            begin
                if (lock_active_reg)
                begin
                    if (lock_count_reg <= 8'd1)
                    begin
                        lock_count_next  = 8'd0;
                        lock_active_next = 1'b0;
                    end
                    else
                    begin
                        lock_count_next = lock_count_reg - 8'd1;
                    end
                end
                if (wd_active_reg)
                begin
                    if (wd_count_reg <= 8'd1)
                    begin
                        // Expiry forces a close and rearms, so it repeats
                        // until a position report showing the shutter closed arrives.
                        out_next.watchdog_fired = 1'b1;
                        goal_next               = 1'b0;
                        out_next.cmd_valid      = 1'b1;
                        wd_active_next          = 1'b1;
                        wd_count_next           = fail_reg;
                        if (pending_reg)
                        begin
                            out_next.reply_valid    = 1'b1;
                            out_next.reply_deferred = 1'b1;
                            out_next.reply_status   = ST_CRIT;
                            pending_next            = 1'b0;
                        end
                    end
                    else
                    begin
                        wd_count_next = wd_count_reg - 8'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        out_next.lockout_busy = lock_active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reported_reg    <= 1'b0;
            goal_reg        <= 1'b0;
            lock_active_reg <= 1'b0;
            lock_count_reg  <= 8'd0;
            wd_active_reg   <= 1'b0;
            wd_count_reg    <= 8'd0;
            pending_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                reported_reg    <= reported_next;
                goal_reg        <= goal_next;
                lock_active_reg <= lock_active_next;
                lock_count_reg  <= lock_count_next;
                wd_active_reg   <= wd_active_next;
                wd_count_reg    <= wd_count_next;
                pending_reg     <= pending_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= out_next;
        end
    end

endmodule
